// File: design/btfa_pkg.sv
// Shared definitions for the first-fit block table allocator.
// Holds default sizes, register indexes, status codes, request kinds and table entry bits.
// No dependencies.
package btfa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned BLOCK_SIZE_DEF = 4096;

  localparam logic [10:0] BLOCK_COUNT_RST = 11'd1024;

  // Configuration register indexes.
  localparam logic REG_HEAP_BASE   = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // Status codes of a result item.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOMEM = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  // Request kinds carried on the input tuser.
  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  // Table entry layout: bit 0 taken, bit 1 chained to the next block.
  localparam int unsigned ENT_TAKEN_BIT = 0;
  localparam int unsigned ENT_NEXT_BIT  = 1;

endpackage

// File: design/block_table_first_fit_allocator.sv
// Flow: an allocate passes ST_CHECK, ST_SCAN over the table entries, ST_MARK over the blocks
// it takes and ST_FINISH; a free passes ST_CHECK, ST_WALK along its chain and ST_FINISH. A zero
// size or a free below the base goes straight to ST_FINISH, a size or block index past the count
// from ST_CHECK. The table port reads or writes one entry per cycle. Input is ready again as the
// result appears; no new item is taken before then. BLOCK_SIZE is a power of two.
// Reset is synchronous; a clearing pass over all MAX_BLOCKS entries follows and accepts no item.
// Top level of the first-fit block table allocator. Depends on btfa_pkg.
module block_table_first_fit_allocator #(
  parameter int unsigned MAX_BLOCKS = btfa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_SIZE = btfa_pkg::BLOCK_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // size_bytes[31:0], free_address[63:32]
  input  logic        s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result_address[31:0], status[33:32], zero fill
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned REM_W = $clog2(BLOCK_SIZE);
  localparam logic [31:0] BS_ADDR = 32'(BLOCK_SIZE);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b000_0001,
    ST_IDLE   = 7'b000_0010,
    ST_CHECK  = 7'b000_0100,
    ST_SCAN   = 7'b000_1000,
    ST_MARK   = 7'b001_0000,
    ST_WALK   = 7'b010_0000,
    ST_FINISH = 7'b100_0000
  } state_t;

  state_t state;

  logic [31:0]      heap_base;
  logic [10:0]      block_count;
  logic [CNT_W-1:0] n_eff;

  logic             is_free;
  logic [31:0]      quot;
  logic [32:0]      need_full;

  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] run_inc;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] eidx;
  logic [CNT_W-1:0] start;
  logic             pend;
  logic [31:0]      cur_addr;
  logic [31:0]      start_addr;
  logic             hit;
  logic             at_last;
  logic             walk_end;

  logic [31:0]      res_addr;
  logic [1:0]       res_status;
  logic [31:0]      out_addr;
  logic [1:0]       out_status;
  logic             out_valid;

  logic [1:0]       table_mem [MAX_BLOCKS];
  logic [1:0]       rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [1:0]       mem_wd;

  assign n_eff = (32'(block_count) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                       : CNT_W'(block_count);

  assign need_full = {1'b0, quot} + 33'd1;

  assign run_inc  = run + CNT_W'(1);
  assign at_last  = pend && (eidx == n_eff - CNT_W'(1));
  assign hit      = pend && !rd_data[btfa_pkg::ENT_TAKEN_BIT] && (run_inc == need);
  assign walk_end = pend && (!rd_data[btfa_pkg::ENT_NEXT_BIT] || at_last);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_status, out_addr};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr[IDX_W-1:0];
    mem_wd = 2'b00;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_MARK: begin
        mem_we = 1'b1;
        mem_wd[btfa_pkg::ENT_TAKEN_BIT] = 1'b1;
        mem_wd[btfa_pkg::ENT_NEXT_BIT]  = (need > CNT_W'(1));
      end
      ST_WALK: begin
        mem_we = pend;
        mem_wa = eidx[IDX_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
    rd_data <= table_mem[ptr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      ptr         <= '0;
      pend        <= 1'b0;
      heap_base   <= '0;
      block_count <= btfa_pkg::BLOCK_COUNT_RST;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          btfa_pkg::REG_HEAP_BASE:   heap_base   <= cfg_data;
          btfa_pkg::REG_BLOCK_COUNT: block_count <= cfg_data[10:0];
          default: ;
        endcase
      end

      // In ST_FINISH the output register is reloaded below instead.
      if (out_valid && m_axis_tready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          ptr <= ptr + CNT_W'(1);
          if (ptr == CNT_W'(MAX_BLOCKS - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_axis_tvalid) begin
            is_free  <= (s_axis_tuser == btfa_pkg::ACTION_FREE);
            res_addr <= '0;
            if (s_axis_tuser == btfa_pkg::ACTION_FREE) begin
              if (s_axis_tdata[63:32] < heap_base) begin
                res_status <= btfa_pkg::STATUS_BAD;
                state      <= ST_FINISH;
              end else begin
                quot  <= (s_axis_tdata[63:32] - heap_base) >> REM_W;
                state <= ST_CHECK;
              end
            end else begin
              if (s_axis_tdata[31:0] == 32'd0) begin
                res_status <= btfa_pkg::STATUS_BAD;
                state      <= ST_FINISH;
              end else begin
                // Ceiling division as floor of (size - 1) plus one.
                quot  <= (s_axis_tdata[31:0] - 32'd1) >> REM_W;
                state <= ST_CHECK;
              end
            end
          end
        end

        ST_CHECK: begin
          pend <= 1'b0;
          if (is_free) begin
            if (quot >= 32'(n_eff)) begin
              res_status <= btfa_pkg::STATUS_BAD;
              state      <= ST_FINISH;
            end else begin
              ptr   <= quot[CNT_W-1:0];
              state <= ST_WALK;
            end
          end else begin
            if (need_full > 33'(n_eff)) begin
              res_status <= btfa_pkg::STATUS_NOMEM;
              state      <= ST_FINISH;
            end else begin
              need       <= need_full[CNT_W-1:0];
              ptr        <= '0;
              run        <= '0;
              start      <= '0;
              cur_addr   <= heap_base;
              start_addr <= heap_base;
              state      <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          // Reads run one entry ahead of the evaluation of rd_data.
          if (ptr < n_eff) begin
            eidx <= ptr;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (hit) begin
            ptr <= start;
          end else if (ptr < n_eff) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (pend) begin
            cur_addr <= cur_addr + BS_ADDR;
            if (rd_data[btfa_pkg::ENT_TAKEN_BIT]) begin
              run        <= '0;
              start      <= eidx + CNT_W'(1);
              start_addr <= cur_addr + BS_ADDR;
            end else begin
              run <= run_inc;
            end
            if (hit) begin
              res_addr   <= start_addr;
              res_status <= btfa_pkg::STATUS_OK;
              state      <= ST_MARK;
            end else if (at_last) begin
              res_status <= btfa_pkg::STATUS_NOMEM;
              state      <= ST_FINISH;
            end
          end
        end

        ST_MARK: begin
          ptr  <= ptr + CNT_W'(1);
          need <= need - CNT_W'(1);
          if (need == CNT_W'(1)) begin
            state <= ST_FINISH;
          end
        end

        ST_WALK: begin
          if (ptr < n_eff) begin
            ptr  <= ptr + CNT_W'(1);
            eidx <= ptr;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (walk_end) begin
            res_status <= btfa_pkg::STATUS_OK;
            state      <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_addr   <= res_addr;
            out_status <= res_status;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/btfa_checker.sv
// Port-level checks for the first-fit block table allocator.
// Depends on btfa_pkg; bound to block_table_first_fit_allocator at the end of this file.
module btfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A result never carries a status code outside the defined set.
  a_status_known: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[33:32] == btfa_pkg::STATUS_OK ||
                       m_axis_tdata[33:32] == btfa_pkg::STATUS_NOMEM ||
                       m_axis_tdata[33:32] == btfa_pkg::STATUS_BAD))
    else $error("result status out of range");

  // Any result whose status is not OK reports a zero address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[33:32] != btfa_pkg::STATUS_OK) |->
      (m_axis_tdata[31:0] == 32'd0))
    else $error("failed request returned a nonzero address");

  // The table clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready during table clearing");

  // Each accepted item closes the input right after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result item changed");

endmodule

bind block_table_first_fit_allocator btfa_checker u_btfa_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for block_table_first_fit_allocator: drives allocate and free items,
// predicts every reply from a mirror of the block table, and compares field by field.
// Depends on btfa_pkg and the allocator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btfa_pkg::*;

  localparam int unsigned BS   = BLOCK_SIZE_DEF;
  localparam int unsigned NBLK = MAX_BLOCKS_DEF;

  typedef struct {
    logic [31:0] addr;
    logic [1:0]  status;
  } reply_t;

  // Mirror of the allocator: block table, registers and the replies still owed.
  class heap_tracker;
    logic [1:0]  blk_state [NBLK];
    logic [31:0] base;
    logic [10:0] count;
    reply_t      pending_replies[$];
    int unsigned mismatches;

    function void clear();
      foreach (blk_state[i]) blk_state[i] = '0;
      base = '0;
      count = BLOCK_COUNT_RST;
      pending_replies.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] v);
      if (idx == REG_HEAP_BASE) base = v;
      else count = v[10:0];
    endfunction

    function int unsigned usable();
      return (count > NBLK) ? NBLK : count;
    endfunction

    function int unsigned outstanding();
      return pending_replies.size();
    endfunction

    function reply_t predict_alloc(logic [31:0] size);
      reply_t      r;
      logic [63:0] need;
      int unsigned n, run, start;
      bit          found;
      r.addr = '0;
      r.status = STATUS_BAD;
      n = usable();
      run = 0;
      start = 0;
      found = 0;
      if (size == '0) return r;
      // Round up in 64 bits so sizes near the top cannot wrap.
      need = ({32'd0, size} + 64'(BS - 1)) / 64'(BS);
      r.status = STATUS_NOMEM;
      if (need > 64'(n)) return r;
      for (int unsigned i = 0; i < n; i++) begin
        if (blk_state[i][ENT_TAKEN_BIT]) begin
          run = 0;
        end else begin
          run++;
          if (64'(run) == need) begin
            start = i + 1 - run;
            found = 1;
            break;
          end
        end
      end
      if (!found) return r;
      for (int unsigned i = 0; i < need; i++) begin
        blk_state[start + i] = '0;
        blk_state[start + i][ENT_TAKEN_BIT] = 1'b1;
        blk_state[start + i][ENT_NEXT_BIT] = (64'(i + 1) < need);
      end
      r.addr = base + 32'(start * BS);
      r.status = STATUS_OK;
      return r;
    endfunction

    function reply_t predict_free(logic [31:0] fa);
      reply_t      r;
      logic [1:0]  e;
      int unsigned n, blk;
      r.addr = '0;
      r.status = STATUS_BAD;
      n = usable();
      if (fa < base) return r;
      blk = (fa - base) / BS;
      if (blk >= n) return r;
      // The chain walk also stops at the last block in use.
      for (int unsigned i = blk; i < n; i++) begin
        e = blk_state[i];
        blk_state[i] = '0;
        if (!e[ENT_NEXT_BIT]) break;
      end
      r.status = STATUS_OK;
      return r;
    endfunction

    function reply_t note_request(logic act, logic [31:0] size, logic [31:0] fa);
      reply_t r;
      if (act == ACTION_ALLOC) r = predict_alloc(size);
      else r = predict_free(fa);
      pending_replies.push_back(r);
      return r;
    endfunction

    function void check_reply(logic [31:0] addr, logic [1:0] status);
      reply_t exp_r;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected reply addr=%h status=%0d", $realtime, addr, status);
        return;
      end
      exp_r = pending_replies.pop_front();
      if (exp_r.addr !== addr || exp_r.status !== status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reply mismatch: addr exp %h got %h, status exp %0d got %0d",
                   $realtime, exp_r.addr, addr, exp_r.status, status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // size_bytes[31:0], free_address[63:32]
  logic        s_axis_tuser = 1'b0; // action[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // result_address[31:0], status[33:32], zero fill

  heap_tracker sb = new();
  bit          calm = 1'b0;
  int unsigned live_blocks[$];

  block_table_first_fit_allocator uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reply side: ready drops in short bursts until the final stretch of the run.
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_reply(m_axis_tdata[31:0], m_axis_tdata[33:32]);
  end

  task automatic write_reg(input logic idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // Valid stays high between back-to-back items; it is only dropped for a gap or a drain.
  task automatic send_req(input logic act, input logic [31:0] size, input logic [31:0] fa,
                          output reply_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {fa, size};
    s_axis_tuser <= act;
    do @(posedge clk); while (!s_axis_tready);
    r = sb.note_request(act, size, fa);
  endtask

  task automatic alloc_req(input logic [31:0] size);
    reply_t r;
    send_req(ACTION_ALLOC, size, $urandom, r);
    if (r.status == STATUS_OK) live_blocks.push_back((r.addr - sb.base) / BS);
  endtask

  task automatic free_req(input logic [31:0] fa);
    reply_t r;
    send_req(ACTION_FREE, $urandom, fa, r);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Most frees target live allocations so the table fragments and refills.
  task automatic random_item();
    int unsigned pick, n, k, blks;
    logic [31:0] base;
    pick = $urandom_range(0, 99);
    n = sb.usable();
    base = sb.base;
    if (pick >= 53 && pick < 88 && live_blocks.size() == 0) pick = 0;
    if (pick < 45) begin
      blks = $urandom_range(1, 8);
      alloc_req((blks - 1) * BS + $urandom_range(1, BS));
    end else if (pick < 47) begin
      blks = $urandom_range(1, (n > 0) ? n : 1);
      alloc_req((blks - 1) * BS + $urandom_range(1, BS));
    end else if (pick < 50) begin
      alloc_req($urandom);
    end else if (pick < 53) begin
      alloc_req('0);
    end else if (pick < 88) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      blks = live_blocks[k];
      live_blocks.delete(k);
      free_req(base + blks * BS + $urandom_range(0, BS - 1));
    end else if (pick < 94) begin
      free_req($urandom);
    end else begin
      free_req(base + $urandom_range(0, NBLK - 1) * BS + $urandom_range(0, BS - 1));
    end
  endtask

  initial begin
    logic [31:0] base;
    logic [31:0] cnt;
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: zero size, rounding, oversize, non-first and unaligned frees.
    alloc_req(32'd0);
    alloc_req(32'd1);
    alloc_req(BS);
    alloc_req(BS + 1);
    alloc_req(32'hFFFF_FFFF);
    alloc_req(NBLK * BS);
    free_req(3 * BS + 32'h123);
    free_req(2 * BS);
    free_req(5 * BS);
    free_req(NBLK * BS);
    free_req(32'hFFFF_FFFF);
    alloc_req((NBLK - 4) * BS);
    // Only a short free run is left at the end of the table.
    alloc_req(3 * BS);

    // A shrunken count cuts the chain walk; entries past it survive the change.
    settle();
    write_reg(REG_BLOCK_COUNT, 32'd600);
    free_req(2 * BS);
    settle();
    write_reg(REG_BLOCK_COUNT, 32'd2047);
    alloc_req(599 * BS);
    free_req(600 * BS);
    free_req(BS);

    // Region at the top of the address space: below-base frees and address wrap.
    settle();
    write_reg(REG_HEAP_BASE, 32'hFFFF_F000);
    write_reg(REG_BLOCK_COUNT, 32'd2);
    alloc_req(2 * BS);
    free_req(32'd0);
    free_req(32'hFFFF_FFFF);
    alloc_req(2 * BS);
    free_req(32'hFFFF_F800);
    alloc_req(32'd1);
    alloc_req(BS);

    settle();
    write_reg(REG_BLOCK_COUNT, 32'd0);
    alloc_req(32'd1);
    free_req(32'hFFFF_F000);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin
          base = $urandom & ~32'(BS - 1);
          cnt = NBLK;
        end
        1: begin
          base = 32'hFFFF_FFFF;
          cnt = $urandom_range(1, 16);
        end
        2: begin
          base = $urandom;
          cnt = 32'd2047;
        end
        3: begin
          base = $urandom & ~32'(BS - 1);
          cnt = $urandom_range(1, 64);
        end
        4: begin
          base = '0;
          cnt = $urandom_range(0, 2047);
        end
        default: begin
          base = 32'hFFFF_F000 - $urandom_range(0, 2 * NBLK) * BS;
          cnt = NBLK;
          calm = 1'b1;
        end
      endcase
      write_reg(REG_HEAP_BASE, base);
      write_reg(REG_BLOCK_COUNT, cnt);
      repeat (92) random_item();
    end

    settle();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/btfa_pkg.sv
design/block_table_first_fit_allocator.sv
design/btfa_checker.sv
bench/tb_top.sv
